### sv/n_queens_backtrack_solver_macros.svh
// ---------------------------------------------------------------------------
// N-queens solver assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef N_QUEENS_BACKTRACK_SOLVER_MACROS_SVH
`define N_QUEENS_BACKTRACK_SOLVER_MACROS_SVH

// Same-cycle implication.
`define NQBS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nqbs same-cycle check failed");

// Next-cycle implication.
`define NQBS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nqbs next-cycle check failed");

`endif

### sv/nqbs_pkg.sv
// ---------------------------------------------------------------------------
// N-queens solver package
// Sizes, state encoding and the command and status bundles.
// ---------------------------------------------------------------------------
`default_nettype none

package nqbs_pkg;

  localparam int MAX_N   = 8;
  localparam int CAP_N   = (MAX_N < 8) ? MAX_N : 8;
  localparam int COL_W   = $clog2(CAP_N + 1);
  localparam int IDX_W   = $clog2(CAP_N);
  localparam int ROW_W   = 3;
  localparam int CFG_W   = 4;
  localparam int PLC_W   = 24;
  localparam int CNT_W   = 16;
  localparam int RESET_N = 8;

  typedef logic [COL_W-1:0] col_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [ROW_W-1:0] row_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_SEARCH
  } state_t;

  typedef struct packed {
    logic start;
    logic step;
    logic finish;
    logic cfg_we;
  } dp_cmd_t;

  typedef struct packed {
    logic active;
    logic goal;
    logic exhaust;
  } dp_sts_t;

endpackage

`default_nettype wire

### sv/n_queens_backtrack_solver.sv
// The try loop in the datapath makes one placement try or backtrack per cycle, then loads the result.
// A continue without an active search loads an empty result, with no try, once the output is free.
// One request is handled at a time; a new one is not accepted until the result is loaded.
// Reset clears control state and the count and sets the board size to 8; queen rows are not cleared.
// ---------------------------------------------------------------------------
// N-queens backtracking solver
// Top level joining the controller and the datapath.
// ---------------------------------------------------------------------------
`default_nettype none

`include "n_queens_backtrack_solver_macros.svh"

module n_queens_backtrack_solver
  import nqbs_pkg::*;
(
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  output logic             in_ready,
  input  wire              in_restart,
  output logic             out_valid,
  input  wire              out_ready,
  output logic             out_found,
  output logic [PLC_W-1:0] out_placement,
  output logic [CNT_W-1:0] out_solution_number,
  input  wire              cfg_valid,
  output logic             cfg_ready,
  input  wire  [CFG_W-1:0] cfg_board_size
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  nqbs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  nqbs_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .in_restart          (in_restart),
    .cfg_board_size      (cfg_board_size),
    .sts                 (sts),
    .out_found           (out_found),
    .out_placement       (out_placement),
    .out_solution_number (out_solution_number)
  );

  `NQBS_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `NQBS_ASSERT_IMP(a_step_or_finish, cmd.step || cmd.finish, !(cmd.step && cmd.finish))
  `NQBS_ASSERT_IMP(a_empty_placement, out_valid && !out_found, out_placement == '0)
  `NQBS_ASSERT_IMP(a_found_counted, out_valid && out_found, out_solution_number != '0)

endmodule

`default_nettype wire

### sv/nqbs_ctrl.sv
// ---------------------------------------------------------------------------
// N-queens solver controller
// Sequences one request at a time and owns the result valid flag.
// ---------------------------------------------------------------------------
`default_nettype none

module nqbs_ctrl
  import nqbs_pkg::*;
(
  input  wire     clk,
  input  wire     rst_n,
  input  wire     in_valid,
  output logic    in_ready,
  input  wire     cfg_valid,
  output logic    cfg_ready,
  output logic    out_valid,
  input  wire     out_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   done;
  logic   out_free;

  assign done      = !sts.active || sts.goal || sts.exhaust;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (done && out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    cfg_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cfg_ready  = 1'b1;
        cmd.start  = in_valid;
        cmd.cfg_we = cfg_valid;
      end
      ST_SEARCH: begin
        cmd.step   = !done;
        cmd.finish = done && out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

### sv/nqbs_dp.sv
// ---------------------------------------------------------------------------
// N-queens solver datapath
// Board registers, conflict check, one placement try or backtrack per step, result load.
// ---------------------------------------------------------------------------
`default_nettype none

module nqbs_dp
  import nqbs_pkg::*;
(
  input  wire              clk,
  input  wire              rst_n,
  input  dp_cmd_t          cmd,
  input  wire              in_restart,
  input  wire  [CFG_W-1:0] cfg_board_size,
  output dp_sts_t          sts,
  output logic             out_found,
  output logic [PLC_W-1:0] out_placement,
  output logic [CNT_W-1:0] out_solution_number
);

  typedef logic [COL_W:0] diag_t;

  function automatic col_t eff_n(input logic [CFG_W-1:0] v);
    col_t n;
    begin
      if (v == '0) begin
        n = col_t'(1);
      end else if (int'(v) > CAP_N) begin
        n = col_t'(CAP_N);
      end else begin
        n = col_t'(v);
      end
      return n;
    end
  endfunction

  row_t             qr_r [CAP_N];
  col_t             n_r, n_nxt;
  col_t             col_r, col_nxt;
  col_t             row_r, row_nxt;
  logic             active_r, active_nxt;
  cnt_t             cnt_r, cnt_nxt;
  logic             found_r, found_nxt;
  logic [PLC_W-1:0] plc_r, plc_nxt;
  cnt_t             num_r, num_nxt;

  col_t             col_min;
  col_t             rd_col;
  idx_t             rd_idx;
  col_t             rd_plus;
  logic             qr_we;
  logic [CAP_N-1:0] conflict;
  logic             row_ok;
  cnt_t             cnt_inc;
  logic [PLC_W-1:0] packed_plc;

  assign col_min = (col_r > n_r) ? n_r : col_r;
  assign rd_col  = (cmd.start ? col_min : col_r) - col_t'(1);
  assign rd_idx  = rd_col[IDX_W-1:0];
  assign rd_plus = col_t'(qr_r[rd_idx]) + col_t'(1);

  assign sts.active  = active_r;
  assign sts.goal    = (col_r >= n_r);
  assign sts.exhaust = (col_r == '0) && (row_r >= n_r);

  always_comb begin
    diag_t q;
    diag_t dc;
    diag_t rw;
    for (int c = 0; c < CAP_N; c++) begin
      q  = diag_t'(qr_r[c]);
      dc = diag_t'(col_r) - diag_t'(c);
      rw = diag_t'(row_r);
      conflict[c] = (col_t'(c) < col_r) && ((q == rw) || (q + dc == rw) || (rw + dc == q));
    end
  end

  assign row_ok = (conflict == '0);

  always_comb begin
    packed_plc = '0;
    for (int c = 0; c < CAP_N; c++) begin
      if (col_t'(c) < n_r) packed_plc[ROW_W*c +: ROW_W] = qr_r[c];
    end
  end

  assign cnt_inc = (cnt_r == '1) ? cnt_r : cnt_r + cnt_t'(1);

  always_comb begin
    n_nxt      = n_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    active_nxt = active_r;
    cnt_nxt    = cnt_r;
    found_nxt  = found_r;
    plc_nxt    = plc_r;
    num_nxt    = num_r;
    qr_we      = 1'b0;
    if (cmd.cfg_we) begin
      n_nxt      = eff_n(cfg_board_size);
      active_nxt = 1'b0;
    end
    if (cmd.start) begin
      if (in_restart) begin
        active_nxt = 1'b1;
        cnt_nxt    = '0;
        col_nxt    = '0;
        row_nxt    = '0;
      end else if (active_r) begin
        if (col_min == '0) begin
          col_nxt = '0;
          row_nxt = n_r;
        end else begin
          col_nxt = rd_col;
          row_nxt = rd_plus;
        end
      end
    end
    if (cmd.step) begin
      if (row_r >= n_r) begin
        col_nxt = rd_col;
        row_nxt = rd_plus;
      end else if (row_ok) begin
        qr_we   = 1'b1;
        col_nxt = col_r + col_t'(1);
        row_nxt = '0;
      end else begin
        row_nxt = row_r + col_t'(1);
      end
    end
    if (cmd.finish) begin
      if (active_r && sts.goal) begin
        cnt_nxt   = cnt_inc;
        col_nxt   = n_r;
        found_nxt = 1'b1;
        plc_nxt   = packed_plc;
        num_nxt   = cnt_inc;
      end else begin
        found_nxt  = 1'b0;
        plc_nxt    = '0;
        num_nxt    = cnt_r;
        if (active_r) begin
          active_nxt = 1'b0;
          col_nxt    = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r      <= eff_n(CFG_W'(RESET_N));
      col_r    <= '0;
      active_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      n_r      <= n_nxt;
      col_r    <= col_nxt;
      active_r <= active_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r   <= row_nxt;
    found_r <= found_nxt;
    plc_r   <= plc_nxt;
    num_r   <= num_nxt;
    if (qr_we) qr_r[col_r[IDX_W-1:0]] <= row_r[ROW_W-1:0];
  end

  assign out_found           = found_r;
  assign out_placement       = plc_r;
  assign out_solution_number = num_r;

endmodule

`default_nettype wire
